// File: hw/rtl/czq_pkg.sv
package czq_pkg;

  localparam int COORD_BITS  = 24;
  localparam int RADIUS_BITS = 21;
  localparam int Q8_BITS     = 8;
  localparam int LIMIT_BITS  = 6;
  localparam int TOTAL_BITS  = 6;
  localparam int CFG_BITS    = 8;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_REG  = 2'd0;
  localparam kind_t KIND_HIT  = 2'd1;
  localparam kind_t KIND_NEAR = 2'd2;
  localparam kind_t KIND_NONE = 2'd3;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MERGE_FACTOR = 1'b0;
  localparam cfg_idx_t CFG_ZONE_LIMIT   = 1'b1;

  localparam logic [Q8_BITS-1:0]    Q8_RESET    = 8'd192;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 6'd32;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [RADIUS_BITS-1:0] radius_t;
  typedef logic [TOTAL_BITS-1:0] total_t;

  typedef struct packed {
    kind_t   kind;
    coord_t  pos_x;
    coord_t  pos_y;
    coord_t  pos_z;
    radius_t span;
  } req_t;

  typedef struct packed {
    logic    hit;
    logic    merged;
    logic    match_valid;
    coord_t  out_x;
    coord_t  out_y;
    coord_t  out_z;
    radius_t out_radius;
    total_t  zone_total;
    logic    last;
  } res_t;

  typedef struct packed {
    coord_t  cx;
    coord_t  cy;
    coord_t  cz;
    radius_t r;
  } zone_t;

  typedef enum logic [2:0] {
    OUT_PEND,
    OUT_NONE,
    OUT_MERGE,
    OUT_APPEND,
    OUT_HIT
  } out_sel_e;

  typedef struct packed {
    logic     load_req;
    logic     flush;
    logic     rd_en;
    logic     rd_last;
    logic     pend_load;
    logic     wr_en;
    logic     wr_merge;
    logic     out_en;
    out_sel_e out_sel;
    logic     out_last;
    logic     out_hit;
    total_t   total;
  } cmd_t;

  typedef struct packed {
    logic ev_valid;
    logic ev_match;
    logic ev_last;
  } status_t;

endpackage

// File: hw/rtl/czq_datapath.sv
module czq_datapath #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  czq_pkg::req_t              req_i,
  input  logic [czq_pkg::Q8_BITS-1:0] q8_i,
  input  czq_pkg::cmd_t              cmd_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_slot_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_slot_i,
  output czq_pkg::status_t           status_o,
  output logic                       res_valid_o,
  output czq_pkg::res_t              res_o
);

  localparam int IW       = $clog2(TABLE_DEPTH);
  localparam int C        = czq_pkg::COORD_BITS;
  localparam int RB       = czq_pkg::RADIUS_BITS;
  localparam int SQ_BITS  = 2 * C;
  localparam int CMP_BITS = SQ_BITS + 2;
  localparam int T_BITS   = RB + czq_pkg::Q8_BITS;
  localparam int TT_BITS  = 2 * T_BITS;
  localparam int R2_BITS  = 2 * RB;
  localparam int SHIFT    = 2 * czq_pkg::Q8_BITS;

  function automatic logic [C-1:0] abs_diff(czq_pkg::coord_t a, czq_pkg::coord_t b);
    logic [C:0] d;
    logic [C:0] n;
    d = {a[C-1], a} - {b[C-1], b};
    n = ~d + 1'b1;
    return d[C] ? n[C-1:0] : d[C-1:0];
  endfunction

  czq_pkg::zone_t zone_mem_q [TABLE_DEPTH];

  czq_pkg::req_t  req_q;
  logic [R2_BITS-1:0] span2_q;
  czq_pkg::radius_t r_in;

  logic v1_q, v2_q, v3_q, v4_q;
  logic last1_q, last2_q, last3_q, last4_q;
  logic [IW-1:0] slot1_q, slot2_q, slot3_q, slot4_q;
  czq_pkg::zone_t e1_q, e2_q, e3_q, e4_q;
  czq_pkg::radius_t mr2_q, mr3_q, mr4_q;
  logic [C-1:0] adx_q, ady_q, adz_q;
  logic [SQ_BITS-1:0] sqx_q, sqy_q, sqz_q;
  logic [R2_BITS-1:0] rr3_q, rr4_q;
  logic [T_BITS-1:0] t3_q;
  logic [SQ_BITS:0] sxy_q;
  logic [CMP_BITS-1:0] s3_q;
  logic [TT_BITS-1:0] tt_q;

  czq_pkg::radius_t mr1;
  logic [SQ_BITS-1:0] sqx_d, sqy_d, sqz_d;
  logic [R2_BITS-1:0] rr_d, span2_d;
  logic [T_BITS-1:0] t_d;
  logic [TT_BITS-1:0] tt_d;
  logic [SQ_BITS:0] sxy_d;
  logic [CMP_BITS-1:0] s3_d;
  logic match;

  czq_pkg::zone_t pend_e_q;
  czq_pkg::radius_t pend_mr_q;
  logic [IW-1:0] pend_slot_q;

  czq_pkg::zone_t wr_data;
  logic [IW-1:0] wr_addr;

  czq_pkg::res_t res_d, res_q;
  logic res_valid_q;

  assign r_in    = (req_q.span == '0) ? RB'(1) : req_q.span;
  assign mr1     = (e1_q.r > r_in) ? e1_q.r : r_in;
  assign span2_d = req_i.span * req_i.span;
  assign sqx_d   = adx_q * adx_q;
  assign sqy_d   = ady_q * ady_q;
  assign sqz_d   = adz_q * adz_q;
  assign rr_d    = e2_q.r * e2_q.r;
  assign t_d     = mr2_q * q8_i;
  assign tt_d    = t3_q * t3_q;
  assign sxy_d   = (SQ_BITS+1)'(sqx_q) + (SQ_BITS+1)'(sqy_q);
  assign s3_d    = CMP_BITS'(sxy_d) + CMP_BITS'(sqz_q);

  always_comb begin
    case (req_q.kind)
      czq_pkg::KIND_REG: match = s3_q <= CMP_BITS'(tt_q >> SHIFT);
      czq_pkg::KIND_HIT: match = CMP_BITS'(sxy_q) <= CMP_BITS'(rr4_q);
      default:           match = CMP_BITS'(sxy_q) <= CMP_BITS'(span2_q);
    endcase
  end

  assign status_o.ev_valid = v4_q;
  assign status_o.ev_match = v4_q & match;
  assign status_o.ev_last  = v4_q & last4_q;

  assign wr_addr = cmd_i.wr_merge ? pend_slot_q : wr_slot_i;

  always_comb begin
    if (cmd_i.wr_merge) begin
      wr_data = '{cx: pend_e_q.cx, cy: pend_e_q.cy, cz: pend_e_q.cz, r: pend_mr_q};
    end else begin
      wr_data = '{cx: req_q.pos_x, cy: req_q.pos_y, cz: req_q.pos_z, r: r_in};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      zone_mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      e1_q <= zone_mem_q[rd_slot_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      v1_q        <= cmd_i.rd_en & ~cmd_i.flush;
      v2_q        <= v1_q & ~cmd_i.flush;
      v3_q        <= v2_q & ~cmd_i.flush;
      v4_q        <= v3_q & ~cmd_i.flush;
      res_valid_q <= cmd_i.out_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q   <= req_i;
      span2_q <= span2_d;
    end
    last1_q <= cmd_i.rd_last;
    slot1_q <= rd_slot_i;
    last2_q <= last1_q;
    slot2_q <= slot1_q;
    e2_q    <= e1_q;
    mr2_q   <= mr1;
    adx_q   <= abs_diff(e1_q.cx, req_q.pos_x);
    ady_q   <= abs_diff(e1_q.cy, req_q.pos_y);
    adz_q   <= abs_diff(e1_q.cz, req_q.pos_z);
    last3_q <= last2_q;
    slot3_q <= slot2_q;
    e3_q    <= e2_q;
    mr3_q   <= mr2_q;
    sqx_q   <= sqx_d;
    sqy_q   <= sqy_d;
    sqz_q   <= sqz_d;
    rr3_q   <= rr_d;
    t3_q    <= t_d;
    last4_q <= last3_q;
    slot4_q <= slot3_q;
    e4_q    <= e3_q;
    mr4_q   <= mr3_q;
    rr4_q   <= rr3_q;
    sxy_q   <= sxy_d;
    s3_q    <= s3_d;
    tt_q    <= tt_d;
    if (cmd_i.pend_load) begin
      pend_e_q    <= e4_q;
      pend_mr_q   <= mr4_q;
      pend_slot_q <= slot4_q;
    end
    if (cmd_i.out_en) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    res_d            = '0;
    res_d.zone_total = cmd_i.total;
    res_d.last       = cmd_i.out_last;
    case (cmd_i.out_sel)
      czq_pkg::OUT_PEND: begin
        res_d.match_valid = 1'b1;
        res_d.out_x       = pend_e_q.cx;
        res_d.out_y       = pend_e_q.cy;
        res_d.out_z       = pend_e_q.cz;
        res_d.out_radius  = pend_e_q.r;
      end
      czq_pkg::OUT_MERGE: begin
        res_d.merged      = 1'b1;
        res_d.match_valid = 1'b1;
        res_d.out_x       = pend_e_q.cx;
        res_d.out_y       = pend_e_q.cy;
        res_d.out_z       = pend_e_q.cz;
        res_d.out_radius  = pend_mr_q;
      end
      czq_pkg::OUT_APPEND: begin
        res_d.match_valid = 1'b1;
        res_d.out_x       = req_q.pos_x;
        res_d.out_y       = req_q.pos_y;
        res_d.out_z       = req_q.pos_z;
        res_d.out_radius  = r_in;
      end
      czq_pkg::OUT_HIT: begin
        res_d.hit = cmd_i.out_hit;
      end
      default: begin
        res_d.match_valid = 1'b0;
      end
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: hw/rtl/czq_ctrl.sv
module czq_ctrl #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  czq_pkg::kind_t                kind_i,
  input  logic [czq_pkg::LIMIT_BITS-1:0] limit_i,
  input  czq_pkg::status_t              status_i,
  output czq_pkg::cmd_t                 cmd_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] rd_slot_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] wr_slot_o,
  output logic                          busy_o
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int LW = ((CW > czq_pkg::LIMIT_BITS) ? CW : czq_pkg::LIMIT_BITS) + 1;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_WAIT     = 3'd2;
  localparam logic [2:0] S_REG_END  = 3'd3;
  localparam logic [2:0] S_HIT_END  = 3'd4;
  localparam logic [2:0] S_NEAR_END = 3'd5;

  function automatic logic [IW-1:0] wrap(logic [IW-1:0] a, logic [CW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s >= SW'(TABLE_DEPTH)) begin
      s = s - SW'(TABLE_DEPTH);
    end
    return s[IW-1:0];
  endfunction

  logic [2:0] state_q, state_d;
  czq_pkg::kind_t kind_q, kind_d;
  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] held_q, held_d;
  logic [IW-1:0] oldest_q, oldest_d;
  logic found_q, found_d;
  logic pend_q, pend_d;

  logic [LW-1:0] lim_w, cnt1, excess, held_new;
  logic issue_last;

  always_comb begin
    lim_w = LW'(limit_i);
    if (lim_w == '0) begin
      lim_w = LW'(1);
    end else if (lim_w > LW'(TABLE_DEPTH)) begin
      lim_w = LW'(TABLE_DEPTH);
    end
    cnt1 = LW'(held_q) + LW'(1);
    if (cnt1 > lim_w) begin
      excess   = cnt1 - lim_w;
      held_new = lim_w;
    end else begin
      excess   = '0;
      held_new = cnt1;
    end
  end

  assign issue_last = (k_q == CW'(held_q - 1'b1));
  assign rd_slot_o  = wrap(oldest_q, k_q);
  assign wr_slot_o  = wrap(oldest_q, held_q);
  assign busy_o     = (state_q != S_IDLE);

  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    k_d      = k_q;
    held_d   = held_q;
    oldest_d = oldest_q;
    found_d  = found_q;
    pend_d   = pend_q;
    cmd_o    = '0;
    cmd_o.total = czq_pkg::total_t'(held_q);

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_req = 1'b1;
          kind_d  = kind_i;
          k_d     = '0;
          found_d = 1'b0;
          pend_d  = 1'b0;
          if (kind_i != czq_pkg::KIND_NONE) begin
            if (held_q != '0) begin
              state_d = S_SCAN;
            end else if (kind_i == czq_pkg::KIND_REG) begin
              state_d = S_REG_END;
            end else if (kind_i == czq_pkg::KIND_HIT) begin
              state_d = S_HIT_END;
            end else begin
              state_d = S_NEAR_END;
            end
          end
        end
      end
      S_SCAN, S_WAIT: begin
        if (state_q == S_SCAN) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_last = issue_last;
          k_d = k_q + 1'b1;
          if (issue_last) begin
            state_d = S_WAIT;
          end
        end
        if (kind_q == czq_pkg::KIND_NEAR) begin
          if (status_i.ev_match) begin
            cmd_o.pend_load = 1'b1;
            pend_d = 1'b1;
            if (pend_q) begin
              cmd_o.out_en  = 1'b1;
              cmd_o.out_sel = czq_pkg::OUT_PEND;
            end
          end
          if (status_i.ev_last) begin
            state_d = S_NEAR_END;
          end
        end else if (status_i.ev_match) begin
          cmd_o.pend_load = 1'b1;
          cmd_o.flush     = 1'b1;
          found_d = 1'b1;
          state_d = (kind_q == czq_pkg::KIND_REG) ? S_REG_END : S_HIT_END;
        end else if (status_i.ev_last) begin
          state_d = (kind_q == czq_pkg::KIND_REG) ? S_REG_END : S_HIT_END;
        end
      end
      S_REG_END: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.out_en   = 1'b1;
        cmd_o.out_last = 1'b1;
        if (found_q) begin
          cmd_o.wr_merge = 1'b1;
          cmd_o.out_sel  = czq_pkg::OUT_MERGE;
        end else begin
          cmd_o.out_sel = czq_pkg::OUT_APPEND;
          cmd_o.total   = czq_pkg::total_t'(held_new);
          held_d   = CW'(held_new);
          oldest_d = wrap(oldest_q, CW'(excess));
        end
        state_d = S_IDLE;
      end
      S_HIT_END: begin
        cmd_o.out_en   = 1'b1;
        cmd_o.out_last = 1'b1;
        cmd_o.out_sel  = czq_pkg::OUT_HIT;
        cmd_o.out_hit  = found_q;
        state_d = S_IDLE;
      end
      S_NEAR_END: begin
        cmd_o.out_en   = 1'b1;
        cmd_o.out_last = 1'b1;
        cmd_o.out_sel  = pend_q ? czq_pkg::OUT_PEND : czq_pkg::OUT_NONE;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      kind_q   <= czq_pkg::KIND_REG;
      k_q      <= '0;
      held_q   <= '0;
      oldest_q <= '0;
      found_q  <= 1'b0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      kind_q   <= kind_d;
      k_q      <= k_d;
      held_q   <= held_d;
      oldest_q <= oldest_d;
      found_q  <= found_d;
      pend_q   <= pend_d;
    end
  end

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CW'(TABLE_DEPTH))
    else $error("Zone count exceeds the table depth.");

  a_oldest_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oldest_q < IW'(TABLE_DEPTH - 1) || oldest_q == IW'(TABLE_DEPTH - 1))
    else $error("Oldest slot lies outside the table.");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !status_i.ev_valid)
    else $error("Compare pipeline holds an entry while idle.");

  a_end_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REG_END || state_q == S_HIT_END || state_q == S_NEAR_END)
      |=> state_q == S_IDLE)
    else $error("Final state did not return to idle.");

endmodule

// File: hw/rtl/circle_zone_table_merge_query.sv
// Zone table with merge, cover query and near search. A request is taken when start is high
// and busy is low; busy stays high until the last result of that request has been issued.
// A request scans the held zones oldest first, one zone per cycle through the single read
// port of the zone memory, into a four-stage read and squared-distance compare pipeline;
// register and contains requests stop at the first matching zone. Each result is shown
// on res_o for exactly one cycle with res_valid_o high and cannot be stalled; near
// searches may issue one result per cycle, and the result marked last ends the request.
// Configuration writes take effect at once and belong in idle periods.
module circle_zone_table_merge_query #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  czq_pkg::req_t                 req_i,
  output logic                          res_valid_o,
  output czq_pkg::res_t                 res_o,
  input  logic                          cfg_we_i,
  input  czq_pkg::cfg_idx_t             cfg_idx_i,
  input  logic [czq_pkg::CFG_BITS-1:0]  cfg_wdata_i
);

  localparam int IW = $clog2(TABLE_DEPTH);

  logic [czq_pkg::Q8_BITS-1:0]    q8_q;
  logic [czq_pkg::LIMIT_BITS-1:0] limit_q;

  czq_pkg::cmd_t    cmd;
  czq_pkg::status_t status;
  logic [IW-1:0]    rd_slot;
  logic [IW-1:0]    wr_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q8_q    <= czq_pkg::Q8_RESET;
      limit_q <= czq_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        czq_pkg::CFG_MERGE_FACTOR: q8_q    <= cfg_wdata_i[czq_pkg::Q8_BITS-1:0];
        czq_pkg::CFG_ZONE_LIMIT:   limit_q <= cfg_wdata_i[czq_pkg::LIMIT_BITS-1:0];
      endcase
    end
  end

  czq_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .kind_i   (req_i.kind),
    .limit_i  (limit_q),
    .status_i (status),
    .cmd_o    (cmd),
    .rd_slot_o(rd_slot),
    .wr_slot_o(wr_slot),
    .busy_o   (busy)
  );

  czq_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .q8_i       (q8_q),
    .cmd_i      (cmd),
    .rd_slot_i  (rd_slot),
    .wr_slot_i  (wr_slot),
    .status_o   (status),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule
